>>> rtl/hbl_pkg.sv
// ----------------------------------------------------------------------------
// hbl_pkg
// Types, codes and constants shared by the budget limiter files.
// ----------------------------------------------------------------------------
package hbl_pkg;

  localparam int unsigned DefDomainSlots = 16;
  localparam int unsigned DefChunkSlots  = 16;
  localparam logic [31:0] Unlim = 32'hFFFF_FFFF;

  typedef enum logic [2:0] {
    OpTick      = 3'd0,
    OpSetDomain = 3'd1,
    OpSetChunk  = 3'd2,
    OpConsume   = 3'd3,
    OpQuery     = 3'd4
  } op_e;

  typedef enum logic [1:0] {
    StOk     = 2'd0,
    StRefuse = 2'd1,
    StFull   = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CfgGlobalLimit = 2'd0,
    CfgDomainDflt  = 2'd1,
    CfgChunkDflt   = 2'd2
  } cfg_idx_e;

  // Table request: find the key, optionally insert it, optionally write cap
  // or add to spent, or clear every spent count.
  typedef enum logic [2:0] {
    TbLookup = 3'd0,
    TbFind   = 3'd1,
    TbSetCap = 3'd2,
    TbAdd    = 3'd3,
    TbClear  = 3'd4
  } tbl_cmd_e;

  // Top-level sequencer states.
  typedef enum logic [3:0] {
    SIdle, SDom, SDomWait, SChk, SChkWait, SCommit, SDomAdd, SDomAddW,
    SChkAdd, SChkAddW, SOut
  } state_e;

  // Table sequencer states.
  typedef enum logic [2:0] {
    TIdle, TSearch, TRead, TShift, TWrite, TClear, TDone
  } tstate_e;

  typedef struct packed {
    logic        start;
    tbl_cmd_e    cmd;
    logic [31:0] key;
    logic [31:0] value;
    logic [31:0] dflt;
  } tbl_req_t;

  typedef struct packed {
    logic        done;
    logic        found;
    logic        full;
    logic [31:0] cap;
    logic [31:0] spent;
  } tbl_rsp_t;

  function automatic logic [31:0] left_of(logic [31:0] lim, logic [31:0] used);
    if (lim == Unlim) return Unlim;
    if (used >= lim) return 32'd0;
    return lim - used;
  endfunction

  function automatic logic [31:0] sat_add(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? Unlim : s[31:0];
  endfunction

endpackage

>>> rtl/hbl_if.sv
// ----------------------------------------------------------------------------
// hbl_if
// Valid/ready channel interfaces for request, result and config words.
// ----------------------------------------------------------------------------
interface hbl_req_if;
  logic        valid;
  logic        ready;
  logic [2:0]  op;
  logic [31:0] domain_sel;
  logic [31:0] chunk_sel;
  logic [31:0] amount;
  modport source (output valid, op, domain_sel, chunk_sel, amount, input ready);
  modport sink   (input valid, op, domain_sel, chunk_sel, amount, output ready);
endinterface

interface hbl_rsp_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] remaining;
  logic [31:0] domain_overflow_count;
  logic [31:0] chunk_overflow_count;
  modport source (output valid, status, remaining, domain_overflow_count,
                  chunk_overflow_count, input ready);
  modport sink   (input valid, status, remaining, domain_overflow_count,
                  chunk_overflow_count, output ready);
endinterface

interface hbl_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [31:0] data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

>>> rtl/hbl_table.sv
// ----------------------------------------------------------------------------
// hbl_table
// Sorted key table: binary search, shifting insert, cap and spent updates.
// ----------------------------------------------------------------------------
module hbl_table #(
  parameter int unsigned Entries = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  hbl_pkg::tbl_req_t req_i,
  output hbl_pkg::tbl_rsp_t rsp_o
);
  import hbl_pkg::*;

  localparam int unsigned IW = (Entries > 1) ? $clog2(Entries) : 1;
  localparam int unsigned FW = $clog2(Entries + 1);

  logic [31:0] key_q [Entries];
  logic [31:0] cap_q [Entries];
  logic [31:0] spent_q [Entries];

  tstate_e     st_q, st_d;
  logic [FW-1:0] fill_q, fill_d;
  logic [FW-1:0] lo_q, lo_d, hi_q, hi_d, pos_q, pos_d;
  tbl_cmd_e    cmd_q, cmd_d;
  logic [31:0] k_q, k_d, val_q, val_d, dflt_q, dflt_d;
  logic        found_q, found_d, full_q, full_d;
  logic [31:0] cap_o_q, cap_o_d, spent_o_q, spent_o_d;
  logic [FW-1:0] mid;
  logic [FW:0]   mid_sum;

  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid = mid_sum[FW:1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= TIdle;
      fill_q <= '0;
    end else begin
      st_q   <= st_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    lo_q <= lo_d; hi_q <= hi_d; pos_q <= pos_d; cmd_q <= cmd_d;
    k_q <= k_d; val_q <= val_d; dflt_q <= dflt_d;
    found_q <= found_d; full_q <= full_d;
    cap_o_q <= cap_o_d; spent_o_q <= spent_o_d;
  end

  // Memory writes: one entry a cycle.
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      TShift: begin
        if (pos_q != fill_q) begin
          key_q[fill_q[IW-1:0]]   <= key_q[fill_q[IW-1:0] - IW'(1)];
          cap_q[fill_q[IW-1:0]]   <= cap_q[fill_q[IW-1:0] - IW'(1)];
          spent_q[fill_q[IW-1:0]] <= spent_q[fill_q[IW-1:0] - IW'(1)];
        end
      end
      TWrite: begin
        key_q[pos_q[IW-1:0]]   <= k_q;
        cap_q[pos_q[IW-1:0]]   <= cap_o_q;
        spent_q[pos_q[IW-1:0]] <= spent_o_q;
      end
      TClear: begin
        if (pos_q < fill_q) spent_q[pos_q[IW-1:0]] <= '0;
      end
      default: ;
    endcase
  end

  // Shift pointer reuses fill_q as the moving index; it is restored at write.
  logic [FW-1:0] shf_q, shf_d;
  always_ff @(posedge clk_i) shf_q <= shf_d;

  always_comb begin
    st_d = st_q; fill_d = fill_q; lo_d = lo_q; hi_d = hi_q; pos_d = pos_q;
    cmd_d = cmd_q; k_d = k_q; val_d = val_q; dflt_d = dflt_q;
    found_d = found_q; full_d = full_q; cap_o_d = cap_o_q; spent_o_d = spent_o_q;
    shf_d = shf_q;
    rsp_o = '{done: (st_q == TDone), found: found_q, full: full_q,
              cap: cap_o_q, spent: spent_o_q};
    unique case (st_q)
      TIdle: if (req_i.start) begin
        cmd_d = req_i.cmd; k_d = req_i.key; val_d = req_i.value; dflt_d = req_i.dflt;
        lo_d = '0; hi_d = fill_q; found_d = 1'b0; full_d = 1'b0;
        pos_d = '0;
        st_d = (req_i.cmd == TbClear) ? TClear : TSearch;
      end
      TSearch: begin
        if (lo_q < hi_q) begin
          if (key_q[mid[IW-1:0]] < k_q) lo_d = mid + FW'(1);
          else hi_d = mid;
        end else begin
          pos_d = lo_q;
          st_d = TRead;
        end
      end
      TRead: begin
        if (pos_q < fill_q && key_q[pos_q[IW-1:0]] == k_q) begin
          found_d = 1'b1;
          cap_o_d = cap_q[pos_q[IW-1:0]];
          spent_o_d = spent_q[pos_q[IW-1:0]];
          unique case (cmd_q)
            TbSetCap: begin cap_o_d = val_q; st_d = TWrite; end
            TbAdd: begin
              spent_o_d = sat_add(spent_q[pos_q[IW-1:0]], val_q); st_d = TWrite;
            end
            default: st_d = TDone;
          endcase
        end else if (fill_q == FW'(Entries)) begin
          full_d = 1'b1; st_d = TDone;
        end else if (cmd_q == TbLookup) begin
          cap_o_d = dflt_q; spent_o_d = '0; st_d = TDone;
        end else begin
          found_d = 1'b1;
          cap_o_d = (cmd_q == TbSetCap) ? val_q : dflt_q;
          spent_o_d = '0;
          shf_d = fill_q;
          st_d = TShift;
        end
      end
      TShift: begin
        // fill_q walks down from the old fill to pos, moving one entry each cycle
        if (fill_q == pos_q) begin
          fill_d = shf_q + FW'(1);
          st_d = TWrite;
        end else fill_d = fill_q - FW'(1);
      end
      TWrite: st_d = TDone;
      TClear: begin
        if (pos_q < fill_q) pos_d = pos_q + FW'(1);
        else st_d = TDone;
      end
      TDone: st_d = TIdle;
      default: st_d = TIdle;
    endcase
  end

endmodule

>>> rtl/hierarchical_budget_limiter.sv
// ----------------------------------------------------------------------------
// hierarchical_budget_limiter
// Per-tick admission control over global, domain and chunk budgets.
// ----------------------------------------------------------------------------
// channel  dir  word
// req      in   op, domain_sel, chunk_sel, amount
// rsp      out  status, remaining, overflow counts
// cfg      in   index, data
// One request at a time; a table visit is a binary search (up to 5 steps)
// plus, on a miss, a shifting insert that moves one entry a cycle. With 16-entry
// tables the longest request is a consume that inserts at the front of both
// tables. A begin tick sweeps the domain table, then the chunk table.
// Reset clears config, fill counts, used count and overflow counters.
// The result waits in a register until taken; no new request meanwhile.
module hierarchical_budget_limiter #(
  parameter int unsigned DomainSlots = hbl_pkg::DefDomainSlots,
  parameter int unsigned ChunkSlots  = hbl_pkg::DefChunkSlots
) (
  input logic   clk_i,
  input logic   rst_ni,
  hbl_req_if.sink   req,
  hbl_rsp_if.source rsp,
  hbl_cfg_if.sink   cfg
);
  import hbl_pkg::*;

  state_e st_q, st_d;
  logic [2:0]  op_q;
  logic [31:0] did_q, cid_q, amt_q;
  logic [31:0] glim_q, ddef_q, cdef_q, gused_q, gused_d;
  logic [31:0] dovf_q, dovf_d, covf_q, covf_d;
  logic [1:0]  stat_q, stat_d;
  logic [31:0] rem_q, rem_d;
  logic        dhit_q, dhit_d, chit_q, chit_d;
  tbl_req_t dreq, creq;
  tbl_rsp_t drsp, crsp;
  logic [31:0] lvl;

  hbl_table #(.Entries(DomainSlots)) u_dom (.clk_i, .rst_ni, .req_i(dreq), .rsp_o(drsp));
  hbl_table #(.Entries(ChunkSlots))  u_chk (.clk_i, .rst_ni, .req_i(creq), .rsp_o(crsp));

  assign cfg.ready = 1'b1;
  assign req.ready = (st_q == SIdle);
  assign rsp.valid = (st_q == SOut);
  assign rsp.status = stat_q;
  assign rsp.remaining = rem_q;
  assign rsp.domain_overflow_count = dovf_q;
  assign rsp.chunk_overflow_count = covf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= SIdle; glim_q <= '0; ddef_q <= '0; cdef_q <= '0;
      gused_q <= '0; dovf_q <= '0; covf_q <= '0;
    end else begin
      st_q <= st_d; gused_q <= gused_d; dovf_q <= dovf_d; covf_q <= covf_d;
      if (cfg.valid) begin
        unique case (cfg.index)
          CfgGlobalLimit: glim_q <= cfg.data;
          CfgDomainDflt:  ddef_q <= cfg.data;
          CfgChunkDflt:   cdef_q <= cfg.data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req.valid && req.ready) begin
      op_q <= req.op; did_q <= req.domain_sel; cid_q <= req.chunk_sel; amt_q <= req.amount;
    end
    stat_q <= stat_d; rem_q <= rem_d; dhit_q <= dhit_d; chit_q <= chit_d;
  end

  function automatic logic [31:0] combine(logic [31:0] r, logic [31:0] l);
    if (r == Unlim) return l;
    if (l != Unlim && l < r) return l;
    return r;
  endfunction

  always_comb begin
    st_d = st_q; gused_d = gused_q; dovf_d = dovf_q; covf_d = covf_q;
    stat_d = stat_q; rem_d = rem_q; dhit_d = dhit_q; chit_d = chit_q;
    dreq = '{start: 1'b0, cmd: TbFind, key: did_q, value: amt_q, dflt: ddef_q};
    creq = '{start: 1'b0, cmd: TbFind, key: cid_q, value: amt_q, dflt: cdef_q};
    lvl = '0;
    unique case (st_q)
      SIdle: if (req.valid) begin
        stat_d = StOk; rem_d = '0; dhit_d = 1'b0; chit_d = 1'b0;
        st_d = SDom;
      end
      SDom: begin
        st_d = SOut;
        unique case (op_q)
          OpTick: begin
            // sweep the domain table first, then the chunk table
            gused_d = '0;
            dreq.start = 1'b1; dreq.cmd = TbClear;
            st_d = SDomWait;
          end
          OpSetDomain: begin dreq.start = 1'b1; dreq.cmd = TbSetCap; st_d = SDomWait; end
          OpSetChunk: begin creq.start = 1'b1; creq.cmd = TbSetCap; st_d = SChkWait; end
          OpConsume: begin
            if (amt_q == '0) st_d = SOut;
            else if (left_of(glim_q, gused_q) != Unlim && left_of(glim_q, gused_q) < amt_q)
            begin
              stat_d = StRefuse; st_d = SOut;
            end else if (did_q != '0) begin
              dreq.start = 1'b1; st_d = SDomWait;
            end else st_d = SChk;
          end
          OpQuery: begin
            rem_d = left_of(glim_q, gused_q);
            if (did_q != '0) begin
              dreq.start = 1'b1; dreq.cmd = TbLookup; st_d = SDomWait;
            end else st_d = SChk;
          end
          default: st_d = SOut;
        endcase
      end
      SDomWait: if (drsp.done) begin
        lvl = drsp.full ? 32'd0 : left_of(drsp.cap, drsp.spent);
        st_d = SOut;
        if (op_q == OpTick) st_d = SChk;
        else if (op_q == OpQuery) begin
          rem_d = combine(rem_q, lvl); st_d = SChk;
        end else if (drsp.full) begin
          stat_d = StFull; dovf_d = dovf_q + 32'd1;
        end else if (op_q == OpConsume) begin
          if (lvl != Unlim && lvl < amt_q) stat_d = StRefuse;
          else begin dhit_d = 1'b1; st_d = SChk; end
        end
      end
      SChk: begin
        if (op_q == OpTick) begin
          creq.start = 1'b1; creq.cmd = TbClear; st_d = SChkWait;
        end else if (cid_q != '0) begin
          creq.start = 1'b1;
          creq.cmd = (op_q == OpQuery) ? TbLookup : TbFind;
          st_d = SChkWait;
        end else st_d = (op_q == OpConsume) ? SCommit : SOut;
      end
      SChkWait: if (crsp.done) begin
        lvl = crsp.full ? 32'd0 : left_of(crsp.cap, crsp.spent);
        st_d = SOut;
        if (op_q == OpTick) st_d = SOut;
        else if (op_q == OpQuery) rem_d = combine(rem_q, lvl);
        else if (crsp.full) begin
          stat_d = StFull; covf_d = covf_q + 32'd1;
        end else if (op_q == OpConsume) begin
          if (lvl != Unlim && lvl < amt_q) stat_d = StRefuse;
          else begin chit_d = 1'b1; st_d = SCommit; end
        end
      end
      SCommit: begin
        gused_d = sat_add(gused_q, amt_q);
        st_d = SDomAdd;
      end
      SDomAdd: begin
        if (dhit_q) begin dreq.start = 1'b1; dreq.cmd = TbAdd; st_d = SDomAddW; end
        else st_d = SChkAdd;
      end
      SDomAddW: if (drsp.done) st_d = SChkAdd;
      SChkAdd: begin
        if (chit_q) begin creq.start = 1'b1; creq.cmd = TbAdd; st_d = SChkAddW; end
        else st_d = SOut;
      end
      SChkAddW: if (crsp.done) st_d = SOut;
      SOut: if (rsp.ready) st_d = SIdle;
      default: st_d = SIdle;
    endcase
  end

endmodule
